// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent checks on a clock with an active-low reset
`ifndef SYNTH
`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("check failed");
`define ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error("check failed");
`else
`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, prop)
`endif

`endif

// ===== rtl/core/ipt_pkg.sv =====
package ipt_pkg;

  localparam int NumBodies = 9;
  localparam int NumAxes   = 3;
  localparam int PerSample = NumBodies * NumAxes;
  localparam int DivSteps  = 96;
  localparam int LoadAddrW = 15;
  localparam int IdxW      = 16;
  localparam int CfgIdxW   = 1;

  localparam logic [CfgIdxW-1:0] CfgStart = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgStep  = 1'b1;

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdQuery = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_READY = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_TOO_SMALL = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    JOB_LOAD  = 2'd0,
    JOB_QUERY = 2'd1,
    JOB_ERR   = 2'd2
  } job_kind_e;

  typedef struct packed {
    job_kind_e              kind;
    status_e                status;
    logic                   exact;
    logic [IdxW-1:0]        idx;
    logic [31:0]            w;
    logic [LoadAddrW-1:0]   addr;
    logic [63:0]            value;
  } ipt_job_t;

endpackage

// ===== rtl/core/ipt_if.sv =====
interface ipt_req_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [9:0]         entry_date;
  logic [3:0]         entry_body;
  logic [1:0]         entry_axis;
  logic signed [63:0] entry_value;
  logic               entry_final;
  logic signed [63:0] query_time;

  modport source (output valid, cmd, entry_date, entry_body, entry_axis, entry_value,
                  entry_final, query_time, input ready);
  modport sink (input valid, cmd, entry_date, entry_body, entry_axis, entry_value,
                entry_final, query_time, output ready);
endinterface

interface ipt_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [3:0]         body;
  logic [1:0]         axis;
  logic signed [63:0] position;
  logic               last;

  modport source (output valid, status, body, axis, position, last, input ready);
  modport sink (input valid, status, body, axis, position, last, output ready);
endinterface

// ===== rtl/core/interpolated_position_table_core.sv =====
// load: the entry passes the front and the FIFO, and the back writes the table; no result
// query: radix-2 divider in the front, then per component the steps read, difference,
// two 32x32 products, round and register, handshake; 27 components
// the next division overlaps the previous output
// reset: ready flag cleared, start_time 0, step_time 65536, table undefined until loaded
module interpolated_position_table_core #(
  parameter int unsigned NUM_SAMPLES = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ipt_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [63:0]                  cfg_data_i,
  ipt_req_if.sink                      req_i,
  ipt_rsp_if.source                    rsp_o
);
  import ipt_pkg::*;

  logic signed [63:0] start_q;
  logic [62:0] step_q;
  ipt_job_t push_job, pop_job;
  logic push_valid, push_ready, pop_valid, pop_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      step_q <= 63'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgStart: start_q <= cfg_data_i;
        CfgStep:  step_q <= cfg_data_i[62:0];
        default:  start_q <= start_q;
      endcase
    end
  end

  ipt_front #(.NUM_SAMPLES(NUM_SAMPLES)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_i),
    .start_time_i(start_q),
    .step_time_i (step_q),
    .job_o       (push_job),
    .job_valid_o (push_valid),
    .job_ready_i (push_ready)
  );

  ipt_fifo #(.DW($bits(ipt_job_t)), .DEPTH(2)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_data_i (push_job),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .pop_data_o  (pop_job),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready)
  );

  ipt_back #(.NUM_SAMPLES(NUM_SAMPLES)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_i      (pop_job),
    .job_valid_i(pop_valid),
    .job_ready_o(pop_ready),
    .rsp        (rsp_o)
  );

endmodule

// ===== rtl/core/ipt_ram.sv =====
module ipt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 27648
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

// ===== rtl/core/ipt_front.sv =====
module ipt_front #(
  parameter int unsigned NUM_SAMPLES = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  ipt_req_if.sink            req,
  input  logic signed [63:0] start_time_i,
  input  logic [62:0]        step_time_i,
  output ipt_pkg::ipt_job_t  job_o,
  output logic               job_valid_o,
  input  logic               job_ready_i
);
  import ipt_pkg::*;

  localparam int unsigned IW = $clog2(NUM_SAMPLES);
  localparam logic [63:0] Top = 64'(NUM_SAMPLES - 1);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } fstate_e;

  fstate_e state_q, state_d;
  logic ready_q, ready_d;
  logic div_q, div_d;
  ipt_job_t job_q, job_d, div_job;
  logic [63:0] dvd_q, dvd_d;
  logic [62:0] rem_q, rem_d, rem_next;
  logic [95:0] quo_q, quo_d;
  logic [6:0] cnt_q, cnt_d;

  logic [62:0] step_eff;
  logic [63:0] shifted;
  logic ge;
  logic load_ok;
  logic [LoadAddrW-1:0] load_addr;
  logic too_small;
  logic [63:0] mag;
  logic [63:0] i_val;
  logic nz;

  assign step_eff = (step_time_i == '0) ? 63'd1 : step_time_i;
  assign shifted = {rem_q, dvd_q[63]};
  assign ge = shifted >= {1'b0, step_eff};
  assign rem_next = ge ? 63'(shifted - {1'b0, step_eff}) : 63'(shifted);

  assign load_ok = (32'(req.entry_date) < NUM_SAMPLES) && (req.entry_body < 4'(NumBodies))
                   && (req.entry_axis < 2'(NumAxes));
  assign load_addr = LoadAddrW'(LoadAddrW'(req.entry_date) * LoadAddrW'(PerSample)
                     + LoadAddrW'(req.entry_body) * LoadAddrW'(NumAxes)
                     + LoadAddrW'(req.entry_axis));
  assign too_small = req.query_time < start_time_i;
  assign mag = req.query_time - start_time_i;

  assign i_val = quo_q[95:32];
  assign nz = (quo_q[31:0] != '0) || (rem_q != '0);

  always_comb begin
    div_job = '0;
    if ((i_val > Top) || (nz && (i_val >= Top))) begin
      div_job.kind = JOB_ERR;
      div_job.status = ST_TOO_LARGE;
    end else begin
      div_job.kind = JOB_QUERY;
      div_job.exact = !nz;
      div_job.idx = IdxW'(i_val[IW-1:0]);
      div_job.w = quo_q[31:0];
    end
  end

  assign job_o = div_q ? div_job : job_q;
  assign job_valid_o = state_q == F_PUSH;
  assign req.ready = state_q == F_IDLE;

  always_comb begin
    state_d = state_q;
    ready_d = ready_q;
    div_d = div_q;
    job_d = job_q;
    dvd_d = dvd_q;
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    unique case (state_q)
      F_IDLE: begin
        if (req.valid) begin
          if (req.cmd == CmdLoad) begin
            if (req.entry_final) begin
              ready_d = 1'b1;
            end
            if (load_ok) begin
              job_d = '0;
              job_d.kind = JOB_LOAD;
              job_d.addr = load_addr;
              job_d.value = req.entry_value;
              div_d = 1'b0;
              state_d = F_PUSH;
            end
          end else if (!ready_q) begin
            job_d = '0;
            job_d.kind = JOB_ERR;
            job_d.status = ST_NOT_READY;
            div_d = 1'b0;
            state_d = F_PUSH;
          end else if (too_small) begin
            job_d = '0;
            job_d.kind = JOB_ERR;
            job_d.status = ST_TOO_SMALL;
            div_d = 1'b0;
            state_d = F_PUSH;
          end else begin
            dvd_d = mag;
            rem_d = '0;
            quo_d = '0;
            cnt_d = '0;
            div_d = 1'b1;
            state_d = F_DIV;
          end
        end
      end
      F_DIV: begin
        dvd_d = {dvd_q[62:0], 1'b0};
        rem_d = rem_next;
        quo_d = {quo_q[94:0], ge};
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'(DivSteps - 1)) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (job_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      ready_q <= 1'b0;
      div_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      ready_q <= ready_d;
      div_q <= div_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

endmodule

// ===== rtl/core/ipt_fifo.sv =====
module ipt_fifo #(
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [DW-1:0] push_data_i,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  output logic [DW-1:0] pop_data_o,
  output logic          pop_valid_o,
  input  logic          pop_ready_i
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic push, pop;

  assign push_ready_o = cnt_q != CW'(DEPTH);
  assign pop_valid_o = cnt_q != '0;
  assign pop_data_o = mem_q[rd_q];
  assign push = push_valid_i && push_ready_o;
  assign pop = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/core/ipt_back.sv =====
`include "assert_macros.svh"

module ipt_back #(
  parameter int unsigned NUM_SAMPLES = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ipt_pkg::ipt_job_t job_i,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  ipt_rsp_if.source         rsp
);
  import ipt_pkg::*;

  localparam int unsigned AW = $clog2(NUM_SAMPLES * PerSample);

  typedef enum logic [5:0] {
    B_IDLE = 6'b000001,
    B_RD   = 6'b000010,
    B_DIFF = 6'b000100,
    B_MUL  = 6'b001000,
    B_SUM  = 6'b010000,
    B_WAIT = 6'b100000
  } bstate_e;

  bstate_e state_q;
  logic [AW-1:0] base_i_q, base_j_q, base_calc;
  logic [4:0] k_q;
  logic [3:0] body_q;
  logic [1:0] axis_q;
  logic [31:0] w_q;
  logic [63:0] vi_q, mag_q, hi_p_q, lo_p_q;
  logic up_q;
  logic out_valid_q, out_last_q;
  status_e out_status_q;
  logic [3:0] out_body_q;
  logic [1:0] out_axis_q;
  logic [63:0] out_pos_q;

  logic pop, ram_we;
  logic [AW-1:0] addr_a, addr_b;
  logic [63:0] rd_a, rd_b;
  logic up;
  logic [63:0] hi_p, lo_p;
  logic [64:0] t_sum;
  logic out_hs;

  assign job_ready_o = state_q == B_IDLE;
  assign pop = job_valid_i && job_ready_o;
  assign ram_we = pop && (job_i.kind == JOB_LOAD);
  assign base_calc = AW'(AW'(job_i.idx) * AW'(PerSample));
  assign addr_a = base_i_q + AW'(k_q);
  assign addr_b = base_j_q + AW'(k_q);

  ipt_ram #(
    .WIDTH(64),
    .DEPTH(NUM_SAMPLES * PerSample)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (AW'(job_i.addr)),
    .wdata_i  (job_i.value),
    .raddr_a_i(addr_a),
    .raddr_b_i(addr_b),
    .rdata_a_o(rd_a),
    .rdata_b_o(rd_b)
  );

  assign up = $signed(rd_b) >= $signed(rd_a);
  assign hi_p = mag_q[63:32] * w_q;
  assign lo_p = mag_q[31:0] * w_q;
  assign t_sum = 65'(hi_p_q) + ((65'(lo_p_q) + 65'h0_8000_0000) >> 32);
  assign out_hs = out_valid_q && rsp.ready;

  assign rsp.valid = out_valid_q;
  assign rsp.status = out_status_q;
  assign rsp.body = out_body_q;
  assign rsp.axis = out_axis_q;
  assign rsp.position = out_pos_q;
  assign rsp.last = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      out_valid_q <= 1'b0;
      k_q <= '0;
      body_q <= '0;
      axis_q <= '0;
    end else begin
      unique case (state_q)
        B_IDLE: begin
          if (pop && (job_i.kind == JOB_ERR)) begin
            out_valid_q <= 1'b1;
            state_q <= B_WAIT;
          end else if (pop && (job_i.kind == JOB_QUERY)) begin
            k_q <= '0;
            body_q <= '0;
            axis_q <= '0;
            state_q <= B_RD;
          end
        end
        B_RD:   state_q <= B_DIFF;
        B_DIFF: state_q <= B_MUL;
        B_MUL:  state_q <= B_SUM;
        B_SUM: begin
          out_valid_q <= 1'b1;
          state_q <= B_WAIT;
        end
        B_WAIT: begin
          if (out_hs) begin
            out_valid_q <= 1'b0;
            if (out_last_q) begin
              state_q <= B_IDLE;
            end else begin
              k_q <= k_q + 5'd1;
              if (axis_q == 2'(NumAxes - 1)) begin
                axis_q <= '0;
                body_q <= body_q + 4'd1;
              end else begin
                axis_q <= axis_q + 2'd1;
              end
              state_q <= B_RD;
            end
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && (job_i.kind == JOB_QUERY)) begin
      base_i_q <= base_calc;
      base_j_q <= job_i.exact ? base_calc : base_calc + AW'(PerSample);
      w_q <= job_i.w;
    end
    if (pop && (job_i.kind == JOB_ERR)) begin
      out_status_q <= job_i.status;
      out_body_q <= '0;
      out_axis_q <= '0;
      out_pos_q <= '0;
      out_last_q <= 1'b1;
    end
    if (state_q == B_DIFF) begin
      vi_q <= rd_a;
      up_q <= up;
      mag_q <= up ? rd_b - rd_a : rd_a - rd_b;
    end
    if (state_q == B_MUL) begin
      hi_p_q <= hi_p;
      lo_p_q <= lo_p;
    end
    if (state_q == B_SUM) begin
      out_status_q <= ST_OK;
      out_body_q <= body_q;
      out_axis_q <= axis_q;
      out_pos_q <= up_q ? vi_q + 64'(t_sum) : vi_q - 64'(t_sum);
      out_last_q <= k_q == 5'(PerSample - 1);
    end
  end

  `ASSERT_AT(a_err_is_last, clk_i, rst_ni, out_valid_q && (out_status_q != ST_OK) |-> out_last_q && (out_pos_q == '0))
  `ASSERT_AT(a_last_corner, clk_i, rst_ni, out_valid_q && (out_status_q == ST_OK) && out_last_q |-> (out_body_q == 4'(NumBodies - 1)) && (out_axis_q == 2'(NumAxes - 1)))
  `ASSERT_NEVER(a_pop_busy, clk_i, rst_ni, pop && out_valid_q)

endmodule
